### sv/bbpt_pkg.sv
// shared types, widths and command codes for the buzzer beep pattern timer
package bbpt_pkg;

  localparam int TICK_WIDTH = 16;
  localparam int PERIOD_W   = TICK_WIDTH + 1;
  localparam int FIELD_W    = 16;
  localparam int PASS_W     = 16;
  localparam int MODE_W     = 2;

  localparam logic [MODE_W-1:0] MODE_TICK   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BEEP   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REPEAT = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [FIELD_W-1:0] on_ticks;
    logic [FIELD_W-1:0] off_ticks;
    logic [FIELD_W-1:0] repeat_total;
  } item_t;

  typedef struct packed {
    logic accepted;
    logic speaker_level;
    logic pattern_busy;
  } result_t;

endpackage

### sv/bbpt_if.sv
// command and response channel interfaces
interface bbpt_cmd_if;
  logic                              valid;
  logic                              ready;
  logic [bbpt_pkg::MODE_W-1:0]       mode;
  logic [bbpt_pkg::FIELD_W-1:0]      on_ticks;
  logic [bbpt_pkg::FIELD_W-1:0]      off_ticks;
  logic [bbpt_pkg::FIELD_W-1:0]      repeat_total;

  modport source (output valid, mode, on_ticks, off_ticks, repeat_total, input ready);
  modport sink   (input valid, mode, on_ticks, off_ticks, repeat_total, output ready);
endinterface

interface bbpt_rsp_if;
  logic valid;
  logic ready;
  logic accepted;
  logic speaker_level;
  logic pattern_busy;

  modport source (output valid, accepted, speaker_level, pattern_busy, input ready);
  modport sink   (input valid, accepted, speaker_level, pattern_busy, output ready);
endinterface

### sv/bbpt_engine.sv
// beep and pattern state registers with their single-pass update logic
module bbpt_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  bbpt_pkg::item_t   item,
  output bbpt_pkg::result_t result
);

  logic                              speaker_on;
  logic [bbpt_pkg::TICK_WIDTH-1:0]   on_remaining;
  logic                              repeat_busy;
  logic [bbpt_pkg::PERIOD_W-1:0]     period_remaining;
  logic [bbpt_pkg::PERIOD_W-1:0]     period_length;
  logic [bbpt_pkg::TICK_WIDTH-1:0]   pattern_beep_length;
  logic [bbpt_pkg::PASS_W-1:0]       passes_target;
  logic [bbpt_pkg::PASS_W-1:0]       passes_done;

  logic                              speaker_on_next;
  logic [bbpt_pkg::TICK_WIDTH-1:0]   on_remaining_next;
  logic                              repeat_busy_next;
  logic [bbpt_pkg::PERIOD_W-1:0]     period_remaining_next;
  logic [bbpt_pkg::PERIOD_W-1:0]     period_length_next;
  logic [bbpt_pkg::TICK_WIDTH-1:0]   pattern_beep_length_next;
  logic [bbpt_pkg::PASS_W-1:0]       passes_target_next;
  logic [bbpt_pkg::PASS_W-1:0]       passes_done_next;
  logic                              acc;

  logic [bbpt_pkg::TICK_WIDTH-1:0]   cmd_len;
  logic [bbpt_pkg::PERIOD_W-1:0]     cmd_period;

  assign cmd_len    = bbpt_pkg::TICK_WIDTH'(item.on_ticks);
  assign cmd_period = bbpt_pkg::PERIOD_W'(item.on_ticks)
                    + bbpt_pkg::PERIOD_W'(item.off_ticks);

  always_comb begin
    speaker_on_next          = speaker_on;
    on_remaining_next        = on_remaining;
    repeat_busy_next         = repeat_busy;
    period_remaining_next    = period_remaining;
    period_length_next       = period_length;
    pattern_beep_length_next = pattern_beep_length;
    passes_target_next       = passes_target;
    passes_done_next         = passes_done;
    acc                      = 1'b0;
    unique case (item.mode)
      bbpt_pkg::MODE_TICK: begin
        acc = 1'b1;
        // running beep counts down first
        if (speaker_on) begin
          on_remaining_next = on_remaining - bbpt_pkg::TICK_WIDTH'(1);
          if (on_remaining_next == '0) begin
            speaker_on_next = 1'b0;
          end
        end
        // then the pattern period
        if (repeat_busy) begin
          period_remaining_next = period_remaining - bbpt_pkg::PERIOD_W'(1);
          if (period_remaining_next == '0) begin
            passes_done_next = passes_done + bbpt_pkg::PASS_W'(1);
            if (passes_done_next >= passes_target) begin
              repeat_busy_next = 1'b0;
            end else begin
              period_remaining_next = period_length;
            end
            // pattern beep try, refused while the speaker is still on
            if (!speaker_on_next && (pattern_beep_length != '0)) begin
              speaker_on_next   = 1'b1;
              on_remaining_next = pattern_beep_length;
            end
          end
        end
      end
      bbpt_pkg::MODE_BEEP: begin
        if (!speaker_on) begin
          acc = 1'b1;
          if (cmd_len != '0) begin
            speaker_on_next   = 1'b1;
            on_remaining_next = cmd_len;
          end
        end
      end
      bbpt_pkg::MODE_REPEAT: begin
        if (!repeat_busy) begin
          acc                      = 1'b1;
          repeat_busy_next         = 1'b1;
          passes_target_next       = bbpt_pkg::PASS_W'(item.repeat_total);
          passes_done_next         = '0;
          // zero period runs as a period of one
          period_length_next       = (cmd_period == '0) ? bbpt_pkg::PERIOD_W'(1)
                                                        : cmd_period;
          period_remaining_next    = period_length_next;
          pattern_beep_length_next = cmd_len;
        end
      end
      default: begin
        acc = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      speaker_on          <= 1'b0;
      on_remaining        <= '0;
      repeat_busy         <= 1'b0;
      period_remaining    <= '0;
      period_length       <= '0;
      pattern_beep_length <= '0;
      passes_target       <= '0;
      passes_done         <= '0;
    end else if (step) begin
      speaker_on          <= speaker_on_next;
      on_remaining        <= on_remaining_next;
      repeat_busy         <= repeat_busy_next;
      period_remaining    <= period_remaining_next;
      period_length       <= period_length_next;
      pattern_beep_length <= pattern_beep_length_next;
      passes_target       <= passes_target_next;
      passes_done         <= passes_done_next;
    end
  end

  assign result.accepted      = acc;
  assign result.speaker_level = speaker_on_next;
  assign result.pattern_busy  = repeat_busy_next;

  a_spk_count: assert property (@(posedge clk) disable iff (rst)
    speaker_on |-> (on_remaining != '0))
    else $error("speaker on with empty beep count");

  a_period_live: assert property (@(posedge clk) disable iff (rst)
    repeat_busy |-> ((period_remaining != '0) && (period_length != '0)))
    else $error("busy pattern with empty period");

  a_spk_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(speaker_on) |-> $past(step))
    else $error("speaker switched on without a transaction");

endmodule

### sv/buzzer_beep_pattern_timer_top.sv
// top level of the buzzer beep pattern timer: input stage, engine, response register
//
// usage
//   cmd carries one transaction per item: mode 0 is a one-millisecond tick,
//   mode 1 a one-shot beep of on_ticks ticks, mode 2 starts a repeat pattern
//   of on_ticks + off_ticks ticks per period for repeat_total periods, or one if zero
//   rsp returns exactly one transaction per cmd transaction, in order:
//   accepted, the speaker level after the item and the pattern busy flag
//   an accepted item is held in the input register, then the engine updates its
//   state and loads the response register, which drives rsp
//   throughput: one item per cycle unless rsp stalls; the engine update is a single
//   pass of counter decrements and compares between the input and response registers
//   reset (rst, synchronous, active high) silences the speaker, stops any
//   pattern, clears all counters and empties both pipeline registers
//   when the receiver stalls, the response register holds its transaction;
//   one more item can still be taken into the input register, after which
//   cmd.ready drops until rsp is taken
module buzzer_beep_pattern_timer_top (
  input  logic              clk,
  input  logic              rst,
  bbpt_cmd_if.sink          cmd,
  bbpt_rsp_if.source        rsp
);

  // input stage
  logic              s1_valid;
  bbpt_pkg::item_t   s1_item;

  // response register
  logic              rsp_valid;
  bbpt_pkg::result_t rsp_data;

  bbpt_pkg::result_t eng_result;
  logic              advance;
  logic              step;

  // response register free or being emptied this cycle
  assign advance   = !rsp_valid || rsp.ready;
  assign step      = s1_valid && advance;
  assign cmd.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.ready) begin
      s1_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready && cmd.valid) begin
      s1_item.mode         <= cmd.mode;
      s1_item.on_ticks     <= cmd.on_ticks;
      s1_item.off_ticks    <= cmd.off_ticks;
      s1_item.repeat_total <= cmd.repeat_total;
    end
  end

  bbpt_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (s1_item),
    .result (eng_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      rsp_data <= eng_result;
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.accepted      = rsp_data.accepted;
  assign rsp.speaker_level = rsp_data.speaker_level;
  assign rsp.pattern_busy  = rsp_data.pattern_busy;

  // a stalled response keeps the input stage from overwriting it
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.ready) |=> rsp_valid)
    else $error("response dropped while stalled");

  // an item in the input stage is handed on once the response side frees up
  a_handoff: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && advance) |=> rsp_valid)
    else $error("item lost between input stage and response register");

  // input stage full and response stalled means no new transaction
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && rsp_valid && !rsp.ready) |-> !cmd.ready)
    else $error("transaction taken with both stages full");

endmodule

### tb/tb_top.sv
// self-checking testbench for the buzzer beep pattern timer top level
module tb_top;

  // mode value three carries no command and must be ignored by the block
  localparam logic [bbpt_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

  localparam int RAND_ITEMS = 1700;  // random commands and ticks, ignored items not counted
  localparam int HOLD_EVERY = 425;   // sender drains the response queue this often
  localparam int TAIL_WAIT  = 6;     // settle time at the end, after the response queue has emptied

  logic clk;
  logic rst;

  bbpt_cmd_if cmd_if ();
  bbpt_rsp_if rsp_if ();

  buzzer_beep_pattern_timer_top uut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .rsp (rsp_if)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // beeper state as the testbench believes it to be
  // ---------------------------------------------------------------------------
  logic                            spk_on       = 1'b0;
  logic [bbpt_pkg::TICK_WIDTH-1:0] beep_left    = '0;
  logic                            pat_busy     = 1'b0;
  logic [bbpt_pkg::PERIOD_W-1:0]   period_left  = '0;
  logic [bbpt_pkg::PERIOD_W-1:0]   period_len   = '0;
  logic [bbpt_pkg::TICK_WIDTH-1:0] pat_beep_len = '0;
  logic [bbpt_pkg::PASS_W-1:0]     pass_target  = '0;
  logic [bbpt_pkg::PASS_W-1:0]     pass_count   = '0;

  bbpt_pkg::result_t expected_q[$];  // responses still owed by the block, oldest first

  int err_count     = 0;
  int rsp_count     = 0;
  int tick_count    = 0;
  int beep_count    = 0;
  int pattern_count = 0;
  int refused_count = 0;
  int ignored_count = 0;

  // a beep is refused while the speaker sounds; a zero length is taken but stays silent
  function automatic logic start_beep(input logic [bbpt_pkg::TICK_WIDTH-1:0] len);
    if (spk_on) return 1'b0;
    if (len != '0) begin
      spk_on    = 1'b1;
      beep_left = len;
    end
    return 1'b1;
  endfunction

  // advances the beeper state by one item and returns the response it owes
  function automatic bbpt_pkg::result_t beeper_step(input bbpt_pkg::item_t it);
    bbpt_pkg::result_t             r;
    logic [bbpt_pkg::PERIOD_W-1:0] p;
    r.accepted = 1'b0;
    case (it.mode)
      bbpt_pkg::MODE_TICK: begin
        // running beep counts down first, then the pattern period
        if (spk_on) begin
          beep_left = beep_left - 1'b1;
          if (beep_left == '0) spk_on = 1'b0;
        end
        if (pat_busy) begin
          period_left = period_left - 1'b1;
          if (period_left == '0) begin
            pass_count = pass_count + 1'b1;
            if (pass_count >= pass_target) pat_busy = 1'b0;
            else period_left = period_len;
            // pattern beep try; a refusal still counts the pass
            void'(start_beep(pat_beep_len));
          end
        end
        r.accepted = 1'b1;
      end
      bbpt_pkg::MODE_BEEP:
        r.accepted = start_beep(bbpt_pkg::TICK_WIDTH'(it.on_ticks));
      bbpt_pkg::MODE_REPEAT: begin
        if (!pat_busy) begin
          p = bbpt_pkg::PERIOD_W'(it.on_ticks) + bbpt_pkg::PERIOD_W'(it.off_ticks);
          if (p == '0) p = bbpt_pkg::PERIOD_W'(1);  // zero period runs as one tick
          pat_busy     = 1'b1;
          pass_target  = bbpt_pkg::PASS_W'(it.repeat_total);
          pass_count   = '0;
          period_len   = p;
          period_left  = p;
          pat_beep_len = bbpt_pkg::TICK_WIDTH'(it.on_ticks);
          r.accepted   = 1'b1;
        end
      end
      default: ;  // unused mode: state untouched, not accepted
    endcase
    r.speaker_level = spk_on;
    r.pattern_busy  = pat_busy;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    err_count++;
  endtask

  // ---------------------------------------------------------------------------
  // command driver: fields change on the falling edge, acceptance seen on the rising edge
  // ---------------------------------------------------------------------------
  task automatic send_item(input bbpt_pkg::item_t it, input logic typed,
                           input bbpt_pkg::result_t typed_r);
    bbpt_pkg::result_t r;
    cmd_if.valid        <= 1'b1;
    cmd_if.mode         <= it.mode;
    cmd_if.on_ticks     <= it.on_ticks;
    cmd_if.off_ticks    <= it.off_ticks;
    cmd_if.repeat_total <= it.repeat_total;
    do @(posedge clk); while (!cmd_if.ready);
    r = beeper_step(it);
    // rows with a hand-written answer are checked against that answer
    expected_q.push_back(typed ? typed_r : r);
    if (it.mode == MODE_UNUSED) ignored_count++;
    else if (!r.accepted) refused_count++;
    else if (it.mode == bbpt_pkg::MODE_TICK) tick_count++;
    else if (it.mode == bbpt_pkg::MODE_BEEP) beep_count++;
    else pattern_count++;
    // valid stays high; the caller either sends again or lowers it
    @(negedge clk);
  endtask

  // random item, shaped by the current state so that most commands do real work
  function automatic bbpt_pkg::item_t pick_item();
    bbpt_pkg::item_t it;
    int              r;
    r               = $urandom_range(0, 99);
    it.on_ticks     = bbpt_pkg::FIELD_W'($urandom_range(0, 16'hFFFF));
    it.off_ticks    = bbpt_pkg::FIELD_W'($urandom_range(0, 16'hFFFF));
    it.repeat_total = bbpt_pkg::FIELD_W'($urandom_range(0, 16'hFFFF));
    if (r < 55) begin
      it.mode = bbpt_pkg::MODE_TICK;  // payload is don't-care, left fully random
    end else if (r < 73) begin
      it.mode = bbpt_pkg::MODE_BEEP;
      // a refused beep may carry any length; a taken one stays short
      if (!spk_on || $urandom_range(0, 3) == 0)
        it.on_ticks = bbpt_pkg::FIELD_W'($urandom_range(0, 12));
    end else if (r < 95) begin
      it.mode = bbpt_pkg::MODE_REPEAT;
      if (!pat_busy || $urandom_range(0, 3) == 0) begin
        it.on_ticks     = bbpt_pkg::FIELD_W'($urandom_range(0, 10));
        it.off_ticks    = bbpt_pkg::FIELD_W'($urandom_range(0, 10));
        it.repeat_total = bbpt_pkg::FIELD_W'($urandom_range(0, 6));
      end
    end else begin
      it.mode = MODE_UNUSED;
    end
    return it;
  endfunction

  // directed table: mode, on, off, total, whether the answer is written in, and the answer
  typedef struct {
    bbpt_pkg::item_t   it;
    logic              typed;
    bbpt_pkg::result_t want;
  } dir_row_t;

  dir_row_t dir_tab[$];

  task automatic row(input logic [bbpt_pkg::MODE_W-1:0] m, input int on_t, input int off_t,
                     input int tot, input logic typed, input logic a, input logic s,
                     input logic b);
    dir_row_t d;
    d.it.mode         = m;
    d.it.on_ticks     = bbpt_pkg::FIELD_W'(on_t);
    d.it.off_ticks    = bbpt_pkg::FIELD_W'(off_t);
    d.it.repeat_total = bbpt_pkg::FIELD_W'(tot);
    d.typed           = typed;
    d.want            = {a, s, b};
    dir_tab.push_back(d);
  endtask

  // ---------------------------------------------------------------------------
  // response checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : rsp_check
    bbpt_pkg::result_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      rsp_count++;
      if (expected_q.size() == 0) begin
        report_mismatch("response with no transaction outstanding");
      end else begin
        want = expected_q.pop_front();
        if (rsp_if.accepted !== want.accepted)
          report_mismatch($sformatf("response %0d accepted %b, wanted %b",
                                    rsp_count, rsp_if.accepted, want.accepted));
        if (rsp_if.speaker_level !== want.speaker_level)
          report_mismatch($sformatf("response %0d speaker_level %b, wanted %b",
                                    rsp_count, rsp_if.speaker_level, want.speaker_level));
        if (rsp_if.pattern_busy !== want.pattern_busy)
          report_mismatch($sformatf("response %0d pattern_busy %b, wanted %b",
                                    rsp_count, rsp_if.pattern_busy, want.pattern_busy));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver back-pressure: one of four ready styles, redrawn when its random run ends
  // ---------------------------------------------------------------------------
  initial begin : rsp_stall
    int style;
    int left;
    style        = 0;
    left         = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        style = $urandom_range(0, 3);
        left  = $urandom_range(10, 150);
      end else begin
        left--;
      end
      case (style)
        0:       rsp_if.ready <= 1'b1;                        // free flowing
        1:       rsp_if.ready <= 1'($urandom_range(0, 1));    // coin toss
        2:       rsp_if.ready <= ($urandom_range(0, 7) == 0); // mostly stalled
        default: rsp_if.ready <= ((left % 12) < 4);           // long regular stalls
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stim
    bbpt_pkg::item_t it;
    int              taken;
    int              burst_left;
    taken               = 0;
    burst_left          = 0;
    rst                 = 1'b1;
    cmd_if.valid        = 1'b0;
    cmd_if.mode         = bbpt_pkg::MODE_TICK;
    cmd_if.on_ticks     = '0;
    cmd_if.off_ticks    = '0;
    cmd_if.repeat_total = '0;

    // tick after reset, ignored mode, silent, sounding and refused beeps
    row(bbpt_pkg::MODE_TICK,   0,       0,       0,       1'b1, 1'b1, 1'b0, 1'b0);
    row(MODE_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 1'b0, 1'b0);
    row(bbpt_pkg::MODE_BEEP,   0,       16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b0, 1'b0);
    row(bbpt_pkg::MODE_BEEP,   3,       0,       0,       1'b1, 1'b1, 1'b1, 1'b0);
    row(bbpt_pkg::MODE_BEEP,   16'hFFFF, 0,       0,       1'b1, 1'b0, 1'b1, 1'b0);
    // pattern starts under a sounding beep; a second pattern is refused
    row(bbpt_pkg::MODE_REPEAT, 2,       0,       2,       1'b0, 1'b0, 1'b0, 1'b0);
    row(bbpt_pkg::MODE_REPEAT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 1'b1, 1'b1);
    // first pass ends while the speaker is still on, so its beep is dropped
    repeat (4) row(bbpt_pkg::MODE_TICK, 0, 0, 0, 1'b0, 1'b0, 1'b0, 1'b0);
    row(bbpt_pkg::MODE_TICK,   16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0, 1'b0);
    // beep ends on the same tick as the period, next pattern beep starts at once
    row(bbpt_pkg::MODE_REPEAT, 1,       0,       2,       1'b0, 1'b0, 1'b0, 1'b0);
    repeat (3) row(bbpt_pkg::MODE_TICK, 0, 0, 0, 1'b0, 1'b0, 1'b0, 1'b0);
    // zero period with a zero total: one tick, one silent beep try
    row(bbpt_pkg::MODE_REPEAT, 0,       0,       0,       1'b0, 1'b0, 1'b0, 1'b0);
    row(bbpt_pkg::MODE_TICK,   0,       0,       0,       1'b0, 1'b0, 1'b0, 1'b0);
    // zero total still gives one audible beep
    row(bbpt_pkg::MODE_REPEAT, 3,       0,       0,       1'b0, 1'b0, 1'b0, 1'b0);
    repeat (6) row(bbpt_pkg::MODE_TICK, 0, 0, 0, 1'b0, 1'b0, 1'b0, 1'b0);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_tab[i]) send_item(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].want);

    // hold off until the directed transactions have all come back
    cmd_if.valid <= 1'b0;
    @(negedge clk);
    while (expected_q.size() != 0) @(negedge clk);

    // random part: bursts of back-to-back transactions separated by random gaps
    while (taken < RAND_ITEMS) begin
      if (burst_left == 0) begin
        cmd_if.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                 : $urandom_range(1, 30);
      end
      it = pick_item();
      send_item(it, 1'b0, '0);
      burst_left--;
      if (it.mode != MODE_UNUSED) begin
        taken++;
        if (taken % HOLD_EVERY == 0) begin
          // let the block empty completely before carrying on
          cmd_if.valid <= 1'b0;
          burst_left = 0;
          @(negedge clk);
          while (expected_q.size() != 0) @(negedge clk);
        end
      end
    end

    // finish any running beep and pattern, then take the widest commands
    while (spk_on || pat_busy) begin
      it      = pick_item();
      it.mode = bbpt_pkg::MODE_TICK;
      send_item(it, 1'b0, '0);
    end
    it.mode         = bbpt_pkg::MODE_REPEAT;
    it.on_ticks     = 16'hFFFF;
    it.off_ticks    = 16'hFFFF;
    it.repeat_total = 16'hFFFF;
    send_item(it, 1'b0, '0);
    it.mode = bbpt_pkg::MODE_BEEP;
    send_item(it, 1'b0, '0);
    it.mode = bbpt_pkg::MODE_TICK;
    repeat (20) send_item(it, 1'b0, '0);
    cmd_if.valid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
    if (expected_q.size() != 0)
      report_mismatch($sformatf("%0d responses never arrived", expected_q.size()));

    $display("run covered %0d responses: %0d ticks, %0d beeps and %0d patterns taken,",
             rsp_count, tick_count, beep_count, pattern_count);
    $display("  %0d commands refused, %0d unused-mode items ignored, %0d mismatches",
             refused_count, ignored_count, err_count);
    if (err_count == 0) begin
      $display("** buzzer_beep_pattern_timer_top: PASSED **");
    end else begin
      $display("** buzzer_beep_pattern_timer_top: FAILED **");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #4000000;
    $display("timeout with %0d responses outstanding", expected_q.size());
    $display("** buzzer_beep_pattern_timer_top: FAILED **");
    $finish;
  end

endmodule
